### rtl/core/mp22s2_pkg.sv
// Package with shared constants and types of the 2x2 stride-2 max pooling block.
package mp22s2_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_WIDTH_DEF   = 32;
  localparam int SAMPLE_BITS_DEF = 32;

  // Field and register widths fixed by the interface.
  localparam int MAP_DIM_W   = 6;
  localparam int CHAN_CNT_W  = 7;
  localparam int FLOOR_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_VALUE_W = 32;
  localparam int ROW_W       = 5;
  localparam int CHAN_W      = 6;

  // Bounds on the effective map height and channel count.
  localparam int HEIGHT_CAP  = 32;
  localparam int CHANNEL_CAP = 64;

  // Register reset values.
  localparam logic [MAP_DIM_W-1:0]  MAP_WIDTH_RST     = 6'd24;
  localparam logic [MAP_DIM_W-1:0]  MAP_HEIGHT_RST    = 6'd24;
  localparam logic [CHAN_CNT_W-1:0] CHANNEL_COUNT_RST = 7'd4;
  localparam logic [FLOOR_W-1:0]    POOL_FLOOR_RST    = 32'hFFF6_0000;  // -10.0 in Q16.16

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH     = 2'd0,
    CFG_MAP_HEIGHT    = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2,
    CFG_POOL_FLOOR    = 2'd3
  } cfg_idx_t;

endpackage

### rtl/core/mp22s2_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mp22s2_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/max_pool_2x2_stride2.sv
// A result is registered in stage one with the beat carrying the second sample of the lower
// pair in its window, and then in the output register that drives the result stream.
// Throughput: one sample beat per cycle unless the output stalls; the line store of upper-row
// pair maxima has one write and one read port, and each sample uses at most one of them.
// Reset (rst_n low, synchronous) clears the position counters, the pair maximum and the
// pipeline valid flags, and loads the register defaults; the line store is not cleared.
module max_pool_2x2_stride2 #(
  parameter int MAX_WIDTH   = mp22s2_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = mp22s2_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [mp22s2_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mp22s2_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  // Sample stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // [SAMPLE_BITS-1:0] sample

  // Pooled result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mp22s2_pkg::OUT_VALUE_W-1:0]  out_tdata,  // [31:0] pooled_value
  output logic                                out_tlast,  // last_of_map
  output logic                                out_tuser   // [0] last_of_all
);

  import mp22s2_pkg::*;

  // Widest map width that counters must cover, and the line store sizes.
  localparam int WIDTH_CAP  = (MAX_WIDTH < 63) ? MAX_WIDTH : 63;
  localparam int COL_BITS   = $clog2(WIDTH_CAP);
  localparam int LINE_DEPTH = WIDTH_CAP / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Configuration registers.
  logic [MAP_DIM_W-1:0]  map_width_r;
  logic [MAP_DIM_W-1:0]  map_height_r;
  logic [CHAN_CNT_W-1:0] channel_count_r;
  logic [FLOOR_W-1:0]    pool_floor_r;

  // Position and pair state.
  logic [COL_BITS-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [CHAN_W-1:0]      chan_r, chan_nxt;
  logic [SAMPLE_BITS-1:0] pair_max_r, pair_max_nxt;

  // Stage one: pair maximum waiting for the line store read.
  logic                   s1_valid_r;
  logic                   s1_emit_r;
  logic                   s1_store_r;
  logic [SAMPLE_BITS-1:0] s1_pair_r;
  logic [ADDR_W-1:0]      s1_slot_r;
  logic                   s1_last_map_r;
  logic                   s1_last_all_r;

  // Output register.
  logic                   out_valid_r;
  logic [OUT_VALUE_W-1:0] out_data_r;
  logic                   out_last_r;
  logic                   out_user_r;

  logic [MAP_DIM_W-1:0]  w_eff, wp, h_eff, hp;
  logic [CHAN_CNT_W-1:0] c_eff;
  logic                  in_area, odd_col, odd_row, end_map, chan_last;
  logic                  col_wrap, row_wrap;
  logic [ADDR_W-1:0]     slot;
  logic [SAMPLE_BITS-1:0] sample, pair_cur;
  logic                  in_acc, s1_go;
  logic                  ram_we, ram_re;
  logic [SAMPLE_BITS-1:0] ram_rdata, floor_ext, upper_max, result;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r     <= MAP_WIDTH_RST;
      map_height_r    <= MAP_HEIGHT_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
      pool_floor_r    <= POOL_FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAP_WIDTH:     map_width_r     <= cfg_wdata[MAP_DIM_W-1:0];
        CFG_MAP_HEIGHT:    map_height_r    <= cfg_wdata[MAP_DIM_W-1:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[CHAN_CNT_W-1:0];
        CFG_POOL_FLOOR:    pool_floor_r    <= cfg_wdata[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective map dimensions: zero acts as one, large values saturate.
  always_comb begin
    if (map_width_r == '0) begin
      w_eff = MAP_DIM_W'(1);
    end else if (map_width_r > MAP_DIM_W'(WIDTH_CAP)) begin
      w_eff = MAP_DIM_W'(WIDTH_CAP);
    end else begin
      w_eff = map_width_r;
    end
    if (map_height_r == '0) begin
      h_eff = MAP_DIM_W'(1);
    end else if (map_height_r > MAP_DIM_W'(HEIGHT_CAP)) begin
      h_eff = MAP_DIM_W'(HEIGHT_CAP);
    end else begin
      h_eff = map_height_r;
    end
    if (channel_count_r == '0) begin
      c_eff = CHAN_CNT_W'(1);
    end else if (channel_count_r > CHAN_CNT_W'(CHANNEL_CAP)) begin
      c_eff = CHAN_CNT_W'(CHANNEL_CAP);
    end else begin
      c_eff = channel_count_r;
    end
  end

  assign wp = {w_eff[MAP_DIM_W-1:1], 1'b0};
  assign hp = {h_eff[MAP_DIM_W-1:1], 1'b0};

  // Position decode of the current sample.
  assign odd_col   = col_r[0];
  assign odd_row   = row_r[0];
  assign in_area   = (CHAN_CNT_W'(col_r) < CHAN_CNT_W'(wp)) && (MAP_DIM_W'(row_r) < hp);
  assign end_map   = (CHAN_CNT_W'(col_r) == CHAN_CNT_W'(wp) - CHAN_CNT_W'(1)) &&
                     (MAP_DIM_W'(row_r) == hp - MAP_DIM_W'(1));
  assign chan_last = (CHAN_CNT_W'(chan_r) + CHAN_CNT_W'(1)) >= c_eff;
  assign col_wrap  = (CHAN_CNT_W'(col_r) + CHAN_CNT_W'(1)) >= CHAN_CNT_W'(w_eff);
  assign row_wrap  = (MAP_DIM_W'(row_r) + MAP_DIM_W'(1)) >= h_eff;
  assign slot      = ADDR_W'(col_r >> 1);

  assign sample = in_tdata[SAMPLE_BITS-1:0];

  // Stage one moves on unless it holds a result and the output register is full.
  assign s1_go     = !s1_valid_r || !s1_emit_r || !out_valid_r || out_tready;
  assign in_tready = s1_go;
  assign in_acc    = in_tvalid && in_tready;

  // Horizontal pair maximum: the even column loads, the odd column compares.
  always_comb begin
    if (!odd_col || ($signed(sample) >= $signed(pair_max_r))) begin
      pair_cur = sample;
    end else begin
      pair_cur = pair_max_r;
    end
  end

  // Raster position and pair maximum update on each accepted beat.
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    chan_nxt     = chan_r;
    pair_max_nxt = pair_max_r;
    if (in_acc) begin
      if (in_area) begin
        pair_max_nxt = pair_cur;
      end
      if (col_wrap) begin
        col_nxt = '0;
        if (row_wrap) begin
          row_nxt  = '0;
          chan_nxt = chan_last ? '0 : chan_r + CHAN_W'(1);
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      chan_r     <= '0;
      pair_max_r <= '0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      chan_r     <= chan_nxt;
      pair_max_r <= pair_max_nxt;
    end
  end

  // Line store: an even row writes the pair maximum, an odd row reads the pair above.
  assign ram_re = in_acc && in_area && odd_col && odd_row;
  assign ram_we = s1_valid_r && s1_store_r;

  mp22s2_ram #(
    .DATA_W (SAMPLE_BITS),
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_slot_r),
    .wdata (s1_pair_r),
    .re    (ram_re),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // Stage one control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      s1_store_r <= 1'b0;
    end else if (s1_go) begin
      s1_valid_r <= in_acc;
      s1_emit_r  <= in_area && odd_col && odd_row;
      s1_store_r <= in_area && odd_col && !odd_row;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_pair_r     <= pair_cur;
      s1_slot_r     <= slot;
      s1_last_map_r <= end_map;
      s1_last_all_r <= end_map && chan_last;
    end
  end

  // Window maximum of the floor, the pair above and the current pair.
  assign floor_ext = SAMPLE_BITS'($signed(pool_floor_r));

  always_comb begin
    if ($signed(ram_rdata) >= $signed(floor_ext)) begin
      upper_max = ram_rdata;
    end else begin
      upper_max = floor_ext;
    end
    if ($signed(s1_pair_r) >= $signed(upper_max)) begin
      result = s1_pair_r;
    end else begin
      result = upper_max;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_emit_r && s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_emit_r && s1_go) begin
      out_data_r <= OUT_VALUE_W'(result);
      out_last_r <= s1_last_map_r;
      out_user_r <= s1_last_all_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // The end of the tensor is always also the end of a map.
  a_all_implies_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("last_of_all without last_of_map");

  // The line store never reads and writes one entry in the same cycle.
  a_no_ram_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re && (s1_slot_r == slot)))
    else $error("line store read and write collide");

  // The input stalls only behind a result that the output cannot take.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && s1_emit_r && out_tvalid && !out_tready)
    else $error("input stalled without a blocked result");

  // A result that leaves stage one is in the output register in the next cycle.
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_emit_r && s1_go |=> out_tvalid)
    else $error("result lost between stage one and output");

endmodule

### tb/sv/tb_max_pool_2x2_stride2.sv
// Self-checking testbench of the 2x2 stride-2 max pooling block.
module tb_max_pool_2x2_stride2;
  import mp22s2_pkg::*;

  localparam int          IN_W          = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int          TOTAL_BEATS   = 1075;
  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LINE_SLOTS    = MAX_WIDTH_DEF / 2;
  localparam logic [31:0] Q_MIN         = 32'h8000_0000;
  localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;

  // One pooled result as it leaves the block.
  typedef struct packed {
    logic [31:0] value;
    logic        last_map;
    logic        last_all;
  } pooled_t;

  // Directed stimulus rows: a register write, a plain sample, or a sample whose
  // result is typed into the table.
  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_SAMPLE_CHK} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [31:0] data;
    pooled_t     want;
  } stim_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_VALUE_W-1:0] out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;

  // Shadow registers and pooling state of the predictor.
  logic [MAP_DIM_W-1:0]  m_width  = MAP_WIDTH_RST;
  logic [MAP_DIM_W-1:0]  m_height = MAP_HEIGHT_RST;
  logic [CHAN_CNT_W-1:0] m_chans  = CHANNEL_COUNT_RST;
  logic [31:0]           m_floor  = POOL_FLOOR_RST;
  logic [31:0]           line_pairs [LINE_SLOTS];
  logic [31:0]           pair_peak = '0;
  int                    col_pos   = 0;
  int                    row_pos   = 0;
  int                    chan_pos  = 0;

  pooled_t   pending_pools [$];
  stim_row_t directed_rows [$];
  int        errors     = 0;
  int        beats_sent = 0;
  int        cycles     = 0;
  bit        steady     = 1'b0;
  bit        hold_req   = 1'b0;

  max_pool_2x2_stride2 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] pooled_value
    .out_tlast  (out_tlast),   // last_of_map
    .out_tuser  (out_tuser)    // [0] last_of_all
  );

  // Clock with a 20 unit period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle counter that ends a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int eff_bound(input int v, input int cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  // Signed Q16.16 maximum.
  function automatic logic [31:0] q_max(input logic [31:0] a, input logic [31:0] b);
    return ($signed(b) >= $signed(a)) ? b : a;
  endfunction

  // Advances the pooling state by one sample and reports the window result, if any.
  task automatic pool_window_step(input logic [31:0] s, output bit emitted,
                                  output pooled_t res);
    int w, h, c, wp, hp, slot;
    bit end_map;
    w  = eff_bound(m_width, MAX_WIDTH_DEF);
    h  = eff_bound(m_height, HEIGHT_CAP);
    c  = eff_bound(m_chans, CHANNEL_CAP);
    wp = w & ~1;
    hp = h & ~1;
    emitted = 1'b0;
    res = '0;
    if (col_pos < wp && row_pos < hp) begin
      slot = col_pos >> 1;
      if (col_pos % 2 == 0) begin
        pair_peak = s;
      end else begin
        pair_peak = q_max(pair_peak, s);
        if (row_pos % 2 == 0) begin
          line_pairs[slot] = pair_peak;
        end else begin
          end_map = (col_pos == wp - 1) && (row_pos == hp - 1);
          res.value = q_max(q_max(m_floor, line_pairs[slot]), pair_peak);
          res.last_map = end_map;
          res.last_all = end_map && (chan_pos + 1 >= c);
          emitted = 1'b1;
        end
      end
    end
    // Position counters wrap at the current bounds.
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        chan_pos = (chan_pos + 1 >= c) ? 0 : chan_pos + 1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (errors < 50) $display("mismatch: %s got %h want %h", what, got, want);
    errors++;
  endtask

  // One register write; the enable is lowered in its own cycle.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MAP_WIDTH:     m_width  = v[MAP_DIM_W-1:0];
      CFG_MAP_HEIGHT:    m_height = v[MAP_DIM_W-1:0];
      CFG_CHANNEL_COUNT: m_chans  = v[CHAN_CNT_W-1:0];
      CFG_POOL_FLOOR:    m_floor  = v;
      default: ;
    endcase
  endtask

  // Offers a sample after a random gap unless steady; records what it should produce.
  task automatic send_sample(input logic [31:0] s, input bit use_want, input pooled_t want);
    bit      emitted;
    pooled_t res;
    while (!steady && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    pool_window_step(s, emitted, res);
    if (use_want) pending_pools.push_back(want);
    else if (emitted) pending_pools.push_back(res);
  endtask

  // Stops the input and lets every expected result and any trailing work finish.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Feeds samples until the next beat starts an even row, so the width may change.
  task automatic realign();
    while (!(col_pos == 0 && row_pos % 2 == 0)) send_sample(pick_sample(), 1'b0, '0);
  endtask

  task automatic table_row(input row_kind_t kind, input cfg_idx_t idx, input logic [31:0] data,
                           input pooled_t want);
    stim_row_t r;
    r.kind = kind;
    r.idx  = idx;
    r.data = data;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  function automatic int pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 2 * $urandom_range(1, 4);
    if (r < 72) return 2 * $urandom_range(1, 4) + 1;
    if (r < 84) return $urandom_range(10, 31);
    if (r < 89) return 32;
    if (r < 93) return $urandom_range(33, 63);
    if (r < 97) return 0;
    return 1;
  endfunction

  function automatic int pick_chans();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, 16);
    if (r < 86) return 64;
    if (r < 91) return $urandom_range(65, 127);
    if (r < 96) return 0;
    return 1;
  endfunction

  function automatic logic [31:0] pick_floor();
    int r;
    r = $urandom_range(99);
    if (r < 30) return POOL_FLOOR_RST;
    if (r < 38) return Q_MIN;
    if (r < 42) return Q_MAX;
    if (r < 52) return 32'd0;
    if (r < 85) return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    return $urandom();
  endfunction

  // Samples: full range, close to the floor, the extremes, and small values.
  function automatic logic [31:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 45) return $urandom();
    if (r < 60) return m_floor + 32'($urandom_range(0, 64)) - 32'd32;
    if (r < 72) begin
      case ($urandom_range(3))
        0: return Q_MIN;
        1: return Q_MAX;
        2: return 32'd0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return 32'($urandom_range(0, 2097152)) - 32'd1048576;
  endfunction

  // Receiver: random back-pressure, a steady stretch, and one long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pools.size() == 0) begin
        report("result with none expected", out_tdata, 32'd0);
      end else begin
        if (out_tdata !== pending_pools[0].value)
          report("pooled_value", out_tdata, pending_pools[0].value);
        if (out_tlast !== pending_pools[0].last_map)
          report("last_of_map", 32'(out_tlast), 32'(pending_pools[0].last_map));
        if (out_tuser !== pending_pools[0].last_all)
          report("last_of_all", 32'(out_tuser), 32'(pending_pools[0].last_all));
        void'(pending_pools.pop_front());
      end
    end
  end

  initial begin
    int      phase, wv, hv, cv, we, he, ce, count;
    bit      aligned;
    foreach (line_pairs[i]) line_pairs[i] = '0;

    // Single 2x2 windows: extremes against the default floor, then floor extremes.
    table_row(ROW_CFG, CFG_MAP_WIDTH, 32'd2, '0);
    table_row(ROW_CFG, CFG_MAP_HEIGHT, 32'd2, '0);
    table_row(ROW_CFG, CFG_CHANNEL_COUNT, 32'd1, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MAX, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, 32'd0, '0);
    table_row(ROW_SAMPLE_CHK, CFG_MAP_WIDTH, 32'd1, '{Q_MAX, 1'b1, 1'b1});
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE_CHK, CFG_MAP_WIDTH, Q_MIN, '{POOL_FLOOR_RST, 1'b1, 1'b1});
    table_row(ROW_CFG, CFG_POOL_FLOOR, Q_MIN, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE_CHK, CFG_MAP_WIDTH, Q_MIN, '{Q_MIN, 1'b1, 1'b1});
    table_row(ROW_CFG, CFG_POOL_FLOOR, Q_MAX, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, 32'h1234_5678, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, 32'd0, '0);
    table_row(ROW_SAMPLE_CHK, CFG_MAP_WIDTH, 32'hFFFF_FFFF, '{Q_MAX, 1'b1, 1'b1});
    // Odd width: the third column of each row is dropped; zero floor beats negatives.
    table_row(ROW_CFG, CFG_POOL_FLOOR, 32'd0, '0);
    table_row(ROW_CFG, CFG_MAP_WIDTH, 32'd3, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, 32'hFFFF_FFFF, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, 32'hFFFF_FFFE, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MAX, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MIN, '0);
    table_row(ROW_SAMPLE_CHK, CFG_MAP_WIDTH, 32'h0001_0000, '{32'h0001_0000, 1'b1, 1'b1});
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MAX, '0);
    // Width zero acts as one, so every sample is dropped.
    table_row(ROW_CFG, CFG_MAP_WIDTH, 32'd0, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MAX, '0);
    table_row(ROW_SAMPLE, CFG_MAP_WIDTH, Q_MAX, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          wait_idle();
          write_reg(directed_rows[i].idx, directed_rows[i].data);
        end
        ROW_SAMPLE:     send_sample(directed_rows[i].data, 1'b0, '0);
        ROW_SAMPLE_CHK: send_sample(directed_rows[i].data, 1'b1, directed_rows[i].want);
        default: ;
      endcase
    end

    // Random phases, each with its own register setting.
    phase = 0;
    while (beats_sent < TOTAL_BEATS) begin
      phase++;
      steady = (phase >= 7 && phase < 11);
      if (phase <= 5 || $urandom_range(3) != 0) realign();
      wait_idle();
      case (phase)
        2: begin wv = 4;  hv = 4;  cv = 8;   end
        3: begin wv = 63; hv = 2;  cv = 1;   end
        4: begin wv = 2;  hv = 2;  cv = 127; end
        5: begin wv = 2;  hv = 63; cv = 0;   end
        default: begin wv = pick_dim(); hv = pick_dim(); cv = pick_chans(); end
      endcase
      aligned = (col_pos == 0 && row_pos % 2 == 0);
      if (!aligned) wv = m_width;
      // Keep each tensor small: large widths go with short maps and few channels.
      we = eff_bound(wv, MAX_WIDTH_DEF);
      he = eff_bound(hv, HEIGHT_CAP);
      if (we * he > 256) begin
        hv = $urandom_range(2, 256 / we);
        he = hv;
      end
      ce = eff_bound(cv, CHANNEL_CAP);
      if (we * he * ce > 320) begin
        cv = (320 / (we * he) > 0) ? 320 / (we * he) : 1;
        ce = cv;
      end
      write_reg(CFG_POOL_FLOOR, pick_floor());
      write_reg(CFG_CHANNEL_COUNT, (32'($urandom()) << CHAN_CNT_W) | 32'(cv));
      write_reg(CFG_MAP_HEIGHT, (32'($urandom()) << MAP_DIM_W) | 32'(hv));
      if (aligned) write_reg(CFG_MAP_WIDTH, (32'($urandom()) << MAP_DIM_W) | 32'(wv));
      if (phase == 2) hold_req = 1'b1;

      count = we * he * ce;
      if (count < 60) count = count * $urandom_range(1, 3);
      // Now and then a broken tensor that stops partway through a map.
      if ($urandom_range(5) == 0) count = count + $urandom_range(1, 2 * we);
      repeat (count) send_sample(pick_sample(), 1'b0, '0);
    end
    steady = 1'b0;

    wait_idle();
    if (errors == 0 && pending_pools.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
